// ----- rtl/line_centroid_tracker_top_assert.svh -----
// assertion macros for the line centroid tracker
`ifndef LINE_CENTROID_TRACKER_TOP_ASSERT_SVH
`define LINE_CENTROID_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LCT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lct_pkg.sv -----
// types and constants of the line centroid tracker
`timescale 1ns / 1ps

package lct_pkg;

  localparam int SENSOR_COUNT_DEF = 4;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam int THR_W      = 12;
  localparam int POS_W      = 16;
  localparam int ALPHA_W    = 16;
  localparam int SCALE_W    = 16;
  localparam int VEL_W      = 32;
  localparam int MUL_W      = 17;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int QUO_W      = 17;
  localparam int OUT_DATA_W = 48;
  localparam int APB_DATA_W = 32;

  localparam logic [THR_W-1:0]   THR_RST   = THR_W'(2048);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(813);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(10000);

  // register map; the alpha and scale indexes follow the position block
  localparam int REG_THRESHOLD = 0;
  localparam int REG_POS_BASE  = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_PREP,
    ST_DIV,
    ST_FILT,
    ST_FUPD,
    ST_VEL,
    ST_DONE
  } lct_state_e;

endpackage

// ----- rtl/line_centroid_tracker_top.sv -----
// line centroid tracker: weighted centroid, low-pass filter and velocity
`timescale 1ns / 1ps
`include "line_centroid_tracker_top_assert.svh"

// Input stream: s_axis_tdata carries SENSOR_COUNT samples, tuser is the
// clear request. Output stream: tdata carries position (low 16 bits) and
// velocity (next 32 bits), tuser is the line-found flag.
// One item is worked at a time through a single shared 17x17 multiplier and
// a restoring divider that resolves one quotient bit per cycle.
// Steps from input transfer to output valid: one multiply-accumulate step per
// sensor, one divider setup step, 17 divider steps, filter multiply, filter
// update, velocity multiply and a result step. A new item is taken only after
// the result step, so each item is finished before the next is accepted. A
// clear request goes straight to the result step, an item with no line right
// after its accumulate steps. The result sits in an output register; the
// block goes back to accepting input while it waits. If the receiver
// stalls with a result still held, the next result waits in the sequencer
// until the register frees. Reset clears the tracker state and loads the
// default register values. Configuration goes over the APB port while
// the block is idle: that is for the user to keep, the block itself
// does not enforce it.
module line_centroid_tracker_top #(
  parameter int SENSOR_COUNT = lct_pkg::SENSOR_COUNT_DEF,
  parameter int SAMPLE_BITS  = lct_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // sample_0 .. sample_N-1, SAMPLE_BITS each, lowest first
  input  logic [((SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // clear_state
  input  logic s_axis_tuser_i,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // line_position [15:0], line_velocity [47:16]
  output logic [lct_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // line_found
  output logic m_axis_tuser_o,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  input  logic psel_i,
  input  logic penable_i,
  input  logic pwrite_i,
  input  logic [$clog2(4*(SENSOR_COUNT+3))-1:0] paddr_i,
  input  logic [lct_pkg::APB_DATA_W-1:0] pwdata_i,
  output logic [lct_pkg::APB_DATA_W-1:0] prdata_o,
  output logic pready_o
);

  localparam int POS_W    = lct_pkg::POS_W;
  localparam int MUL_W    = lct_pkg::MUL_W;
  localparam int PROD_W   = lct_pkg::PROD_W;
  localparam int QUO_W    = lct_pkg::QUO_W;
  localparam int VEL_W    = lct_pkg::VEL_W;
  localparam int THR_W    = lct_pkg::THR_W;
  localparam int DATA_W   = lct_pkg::APB_DATA_W;
  localparam int CNT_W    = $clog2(SENSOR_COUNT);
  localparam int ADDR_W   = $clog2(4*(SENSOR_COUNT+3));
  localparam int IDX_W    = ADDR_W - 2;
  localparam int REG_ALPHA = SENSOR_COUNT + 1;
  localparam int REG_SCALE = SENSOR_COUNT + 2;
  localparam int CMP_W    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int TOT_W    = SAMPLE_BITS + CNT_W;
  localparam int ACC_W    = POS_W + SAMPLE_BITS + CNT_W + 1;
  localparam int NUM_W    = ACC_W + 1;
  localparam int QCNT_W   = $clog2(QUO_W);
  localparam int STEP_W   = (QCNT_W > CNT_W) ? QCNT_W : CNT_W;

  // ---------------- configuration registers ----------------
  logic [THR_W-1:0]                   thr_q;
  logic signed [POS_W-1:0]            pos_q [SENSOR_COUNT];
  logic [lct_pkg::ALPHA_W-1:0]        alpha_q;
  logic [lct_pkg::SCALE_W-1:0]        scale_q;
  logic                               wr_en;
  logic [IDX_W-1:0]                   idx;

  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign idx      = paddr_i[ADDR_W-1:2];
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= lct_pkg::THR_RST;
      alpha_q <= lct_pkg::ALPHA_RST;
      scale_q <= lct_pkg::SCALE_RST;
    end else if (wr_en) begin
      if (idx == IDX_W'(lct_pkg::REG_THRESHOLD)) begin
        thr_q <= pwdata_i[THR_W-1:0];
      end
      if (idx == IDX_W'(REG_ALPHA)) begin
        alpha_q <= pwdata_i[lct_pkg::ALPHA_W-1:0];
      end
      if (idx == IDX_W'(REG_SCALE)) begin
        scale_q <= pwdata_i[lct_pkg::SCALE_W-1:0];
      end
    end
  end

  // sensors spread evenly across the signed range by default
  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_pos
    localparam int POS_RST = -32768 + (65536 * (2*g + 1)) / (2*SENSOR_COUNT);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q[g] <= POS_W'(POS_RST);
      end else if (wr_en && idx == IDX_W'(lct_pkg::REG_POS_BASE + g)) begin
        pos_q[g] <= pwdata_i[POS_W-1:0];
      end
    end
  end

  always_comb begin
    prdata_o = '0;
    if (idx == IDX_W'(lct_pkg::REG_THRESHOLD)) begin
      prdata_o = DATA_W'(thr_q);
    end
    if (idx == IDX_W'(REG_ALPHA)) begin
      prdata_o = DATA_W'(alpha_q);
    end
    if (idx == IDX_W'(REG_SCALE)) begin
      prdata_o = DATA_W'(scale_q);
    end
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (idx == IDX_W'(lct_pkg::REG_POS_BASE + i)) begin
        prdata_o = DATA_W'($unsigned(pos_q[i]));
      end
    end
  end

  // ---------------- sequencer ----------------
  lct_pkg::lct_state_e state_q, state_d;

  logic [STEP_W-1:0]        cnt_q;
  logic [SAMPLE_BITS-1:0]   smp_q  [SENSOR_COUNT];
  logic signed [POS_W-1:0]  posw_q [SENSOR_COUNT];
  logic signed [ACC_W-1:0]  acc_q;
  logic [TOT_W-1:0]         tot_q;
  logic                     found_q;
  logic                     clr_q;
  logic [NUM_W-1:0]         rem_q;
  logic [NUM_W-1:0]         dsr_q;
  logic [QUO_W-1:0]         quo_q;
  logic                     neg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [POS_W-1:0]  filt_q;
  logic                     seen_q;
  logic signed [POS_W-1:0]  pos_est_q;
  logic signed [VEL_W-1:0]  vel_est_q;

  logic                     m_valid_q;
  logic                     m_found_q;
  logic signed [POS_W-1:0]  m_pos_q;
  logic signed [VEL_W-1:0]  m_vel_q;

  logic s_xfer;
  logic out_free;
  logic acc_last;
  logic div_last;
  logic hit;

  assign s_axis_tready_o = (state_q == lct_pkg::ST_IDLE);
  assign s_xfer          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign acc_last        = (cnt_q == STEP_W'(SENSOR_COUNT - 1));
  assign div_last        = (cnt_q == STEP_W'(QUO_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lct_pkg::ST_IDLE: begin
        if (s_xfer) begin
          state_d = s_axis_tuser_i ? lct_pkg::ST_DONE : lct_pkg::ST_ACC;
        end
      end
      lct_pkg::ST_ACC: begin
        if (acc_last) begin
          state_d = (found_q || hit) ? lct_pkg::ST_DIV_PREP : lct_pkg::ST_DONE;
        end
      end
      lct_pkg::ST_DIV_PREP: state_d = lct_pkg::ST_DIV;
      lct_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = lct_pkg::ST_FILT;
        end
      end
      lct_pkg::ST_FILT: state_d = lct_pkg::ST_FUPD;
      lct_pkg::ST_FUPD: state_d = lct_pkg::ST_VEL;
      lct_pkg::ST_VEL:  state_d = lct_pkg::ST_DONE;
      lct_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lct_pkg::ST_IDLE;
        end
      end
      default: state_d = lct_pkg::ST_IDLE;
    endcase
  end

  // ---------------- shared datapath ----------------
  logic [SAMPLE_BITS-1:0]   w;
  logic signed [POS_W-1:0]  raw;
  logic signed [MUL_W-1:0]  diff;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [ACC_W-1:0]         mag;
  logic                     ge;
  logic signed [PROD_W-1:0] rnd;
  logic signed [POS_W-1:0]  filt_new;
  logic signed [VEL_W-1:0]  vel_sat;
  logic [PROD_W-VEL_W:0]    vel_top;

  assign hit = CMP_W'(smp_q[0]) > CMP_W'(thr_q);
  assign w   = hit ? SAMPLE_BITS'(CMP_W'(smp_q[0]) - CMP_W'(thr_q)) : '0;

  // rounded magnitude is at most 2^15, so the low 16 bits carry it
  assign raw  = neg_q ? -POS_W'(quo_q) : POS_W'(quo_q);
  assign diff = MUL_W'((state_q == lct_pkg::ST_VEL) ? filt_q : raw) - MUL_W'(pos_est_q);

  always_comb begin
    unique case (state_q)
      lct_pkg::ST_ACC: begin
        mul_a = MUL_W'(posw_q[0]);
        mul_b = $signed(MUL_W'(w));
      end
      lct_pkg::ST_FILT: begin
        mul_a = diff;
        mul_b = $signed(MUL_W'(alpha_q));
      end
      lct_pkg::ST_VEL: begin
        mul_a = diff;
        mul_b = $signed(MUL_W'(scale_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign ge  = (rem_q >= dsr_q);

  // pos + floor((prod + 2^15) / 2^16), wraps to 16 bits as the result stays in range
  assign rnd      = prod_q + PROD_W'(32768);
  assign filt_new = seen_q ? pos_est_q + rnd[POS_W+15:16] : raw;

  assign vel_top = prod_q[PROD_W-1:VEL_W-1];
  always_comb begin
    if ((&vel_top) || !(|vel_top)) begin
      vel_sat = prod_q[VEL_W-1:0];
    end else if (prod_q[PROD_W-1]) begin
      vel_sat = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      vel_sat = {1'b0, {(VEL_W-1){1'b1}}};
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lct_pkg::ST_IDLE: begin
        if (s_xfer) begin
          for (int i = 0; i < SENSOR_COUNT; i++) begin
            smp_q[i]  <= s_axis_tdata_i[i*SAMPLE_BITS +: SAMPLE_BITS];
            posw_q[i] <= pos_q[i];
          end
          acc_q   <= '0;
          tot_q   <= '0;
          found_q <= 1'b0;
          clr_q   <= s_axis_tuser_i;
        end
      end
      lct_pkg::ST_ACC: begin
        // one sensor per cycle, lines shift down toward entry zero
        for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
          smp_q[i]  <= smp_q[i+1];
          posw_q[i] <= posw_q[i+1];
        end
        acc_q   <= acc_q + ACC_W'(mul_p);
        tot_q   <= tot_q + TOT_W'(w);
        found_q <= found_q | hit;
      end
      lct_pkg::ST_DIV_PREP: begin
        // round to nearest: (2|sum| + tot) / (2 tot)
        rem_q <= {mag, 1'b0} + NUM_W'(tot_q);
        dsr_q <= NUM_W'({tot_q, 1'b0}) << (QUO_W - 1);
        neg_q <= acc_q[ACC_W-1];
      end
      lct_pkg::ST_DIV: begin
        if (ge) begin
          rem_q <= rem_q - dsr_q;
        end
        dsr_q <= dsr_q >> 1;
        quo_q <= {quo_q[QUO_W-2:0], ge};
      end
      lct_pkg::ST_FILT: prod_q <= mul_p;
      lct_pkg::ST_FUPD: filt_q <= filt_new;
      lct_pkg::ST_VEL:  prod_q <= mul_p;
      default: ;
    endcase
  end

  // step counter, tracker state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      seen_q    <= 1'b0;
      pos_est_q <= '0;
      vel_est_q <= '0;
      m_valid_q <= 1'b0;
      m_found_q <= 1'b0;
      m_pos_q   <= '0;
      m_vel_q   <= '0;
    end else begin
      if ((state_q == lct_pkg::ST_ACC && !acc_last) ||
          (state_q == lct_pkg::ST_DIV && !div_last)) begin
        cnt_q <= cnt_q + STEP_W'(1);
      end else begin
        cnt_q <= '0;
      end

      if (state_q == lct_pkg::ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      if (state_q == lct_pkg::ST_DONE && out_free) begin
        if (clr_q) begin
          seen_q    <= 1'b0;
          pos_est_q <= '0;
          vel_est_q <= '0;
          m_found_q <= 1'b0;
          m_pos_q   <= '0;
          m_vel_q   <= '0;
        end else if (!found_q) begin
          seen_q    <= 1'b0;
          m_found_q <= 1'b0;
          m_pos_q   <= pos_est_q;
          m_vel_q   <= vel_est_q;
        end else begin
          seen_q    <= 1'b1;
          pos_est_q <= filt_q;
          vel_est_q <= vel_sat;
          m_found_q <= 1'b1;
          m_pos_q   <= filt_q;
          m_vel_q   <= vel_sat;
        end
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_found_q;
  assign m_axis_tdata_o  = {m_vel_q, m_pos_q};

  // ---------------- assertions ----------------
  `LCT_ASSERT_NEXT(a_start_seq, s_axis_tvalid_i && s_axis_tready_o,
    state_q == lct_pkg::ST_ACC || state_q == lct_pkg::ST_DONE,
    "accepted item did not start the sequencer")
  `LCT_ASSERT_IMPL(a_div_bound, state_q == lct_pkg::ST_DIV,
    (rem_q >> 1) < dsr_q, "divider remainder exceeds quotient range")
  `LCT_ASSERT_IMPL(a_out_load, $rose(m_valid_q),
    $past(state_q == lct_pkg::ST_DONE), "output loaded outside result state")

endmodule
